[hw/rtl/hdc_pkg.sv]
// ----------------------------------------------------------------------------
// hdc_pkg: heater triac duty controller shared types and constants
// Word layouts for the command and result channels, config register indexes
// and the fixed-point constants for the percent-to-ticks conversion.
// ----------------------------------------------------------------------------
package hdc_pkg;

    localparam int unsigned CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONTROL_PERIOD = 1'b0,
        CFG_PWM_CYCLE      = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_SET  = 1'b1
    } t_cmd;

    typedef struct packed {
        logic       command;
        logic       relay_request;
        logic [7:0] duty_percent;
        logic [7:0] delay_periods;
    } t_in_word;

    typedef struct packed {
        logic       relay_on;
        logic       triac_on;
        logic [1:0] heater_status;
        logic [7:0] requested_duty;
    } t_out_word;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [7:0]           data;
    } t_cfg_wr;

    localparam logic [7:0]  RESET_PERIOD_TICKS = 8'd100;
    localparam logic [7:0]  RESET_CYCLE_TICKS  = 8'd100;
    localparam logic [7:0]  FULL_PERCENT       = 8'd100;

    // floor(x / 100) == (x * 5243) >> 19 for every x below 25500
    localparam logic [12:0] DIV100_RECIP       = 13'd5243;
    localparam int unsigned DIV100_SHIFT       = 19;

endpackage

[hw/rtl/hdc_core.sv]
// ----------------------------------------------------------------------------
// hdc_core: heater controller state and per-word update
// Holds config registers, period timer, PWM position, pending request and
// drive states; advances them by one command word when stepped.
// ----------------------------------------------------------------------------
module hdc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hdc_pkg::t_cfg_wr  i_cfg,
    input  logic              i_step,
    input  hdc_pkg::t_in_word i_word,
    output hdc_pkg::t_out_word o_result
);

    logic [7:0]  r_period_ticks, n_period_ticks;
    logic [7:0]  r_cycle_ticks,  n_cycle_ticks;
    logic [7:0]  r_period_timer, n_period_timer;
    logic [7:0]  r_pwm_pos,      n_pwm_pos;
    logic [7:0]  r_applied,      n_applied;
    logic        r_relay,        n_relay;
    logic        r_triac,        n_triac;
    logic        r_pend_relay,   n_pend_relay;
    logic [7:0]  r_pend_duty,    n_pend_duty;
    logic [7:0]  r_delay_left,   n_delay_left;
    logic [15:0] r_pend_prod;

    logic [7:0]  timer_adv;
    logic        period_end;
    logic [8:0]  pos_inc;
    logic [7:0]  delay_dec;
    logic [28:0] quot_prod;
    logic [7:0]  duty_ticks;
    logic        tick_triac;

    always_comb begin
        n_period_ticks = r_period_ticks;
        n_cycle_ticks  = r_cycle_ticks;
        if (i_cfg.valid) begin
            unique case (hdc_pkg::t_cfg_idx'(i_cfg.index))
                hdc_pkg::CFG_CONTROL_PERIOD: n_period_ticks = i_cfg.data;
                hdc_pkg::CFG_PWM_CYCLE:      n_cycle_ticks  = i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        timer_adv  = (r_period_timer < r_period_ticks) ? r_period_timer + 8'd1
                                                       : r_period_timer;
        period_end = (timer_adv >= r_period_ticks);

        if (r_applied == 8'd0) begin
            tick_triac = 1'b0;
        end else begin
            tick_triac = (r_pwm_pos <= r_applied);
        end

        pos_inc   = {1'b0, r_pwm_pos} + 9'd1;
        delay_dec = (r_delay_left != 8'd0) ? r_delay_left - 8'd1 : 8'd0;

        quot_prod  = 29'(r_pend_prod) * 29'(hdc_pkg::DIV100_RECIP);
        duty_ticks = (r_pend_duty >= hdc_pkg::FULL_PERCENT) ? r_cycle_ticks
                   : quot_prod[hdc_pkg::DIV100_SHIFT +: 8];
    end

    always_comb begin
        n_period_timer = r_period_timer;
        n_pwm_pos      = r_pwm_pos;
        n_applied      = r_applied;
        n_relay        = r_relay;
        n_triac        = r_triac;
        n_pend_relay   = r_pend_relay;
        n_pend_duty    = r_pend_duty;
        n_delay_left   = r_delay_left;
        if (i_step) begin
            if (i_word.command == hdc_pkg::CMD_SET) begin
                n_pend_relay = i_word.relay_request;
                n_pend_duty  = i_word.duty_percent;
                n_delay_left = i_word.delay_periods;
            end else begin
                n_triac = tick_triac;
                if (pos_inc > {1'b0, r_cycle_ticks} || pos_inc[8]) begin
                    n_pwm_pos = 8'd0;
                end else begin
                    n_pwm_pos = pos_inc[7:0];
                end
                if (period_end) begin
                    n_period_timer = 8'd0;
                    n_delay_left   = delay_dec;
                    if (delay_dec == 8'd0) begin
                        n_relay   = r_pend_relay;
                        n_applied = duty_ticks;
                    end
                end else begin
                    n_period_timer = timer_adv;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_ticks <= hdc_pkg::RESET_PERIOD_TICKS;
            r_cycle_ticks  <= hdc_pkg::RESET_CYCLE_TICKS;
            r_period_timer <= 8'd0;
            r_pwm_pos      <= 8'd0;
            r_applied      <= 8'd0;
            r_relay        <= 1'b0;
            r_triac        <= 1'b0;
            r_pend_relay   <= 1'b0;
            r_pend_duty    <= 8'd0;
            r_delay_left   <= 8'd0;
            r_pend_prod    <= 16'd0;
        end else begin
            r_period_ticks <= n_period_ticks;
            r_cycle_ticks  <= n_cycle_ticks;
            r_period_timer <= n_period_timer;
            r_pwm_pos      <= n_pwm_pos;
            r_applied      <= n_applied;
            r_relay        <= n_relay;
            r_triac        <= n_triac;
            r_pend_relay   <= n_pend_relay;
            r_pend_duty    <= n_pend_duty;
            r_delay_left   <= n_delay_left;
            r_pend_prod    <= 16'(n_pend_duty) * 16'(n_cycle_ticks);
        end
    end

    always_comb begin
        o_result.relay_on       = n_relay;
        o_result.triac_on       = n_triac;
        o_result.heater_status  = {n_relay, n_triac};
        o_result.requested_duty = n_pend_duty;
    end

endmodule

[hw/rtl/heater_triac_duty_controller.sv]
// An accepted word waits in the input register until the result register can take it.
// Throughput: one command word per cycle while the output is not stalled; each word
// is applied to the controller state in one pass between input and result registers.
// Reset: synchronous active-low; clears valids and core state; config back to 100/100.
// ----------------------------------------------------------------------------
// heater_triac_duty_controller: time-proportional triac PWM with relay latch
// Input register, controller state update, result register with stall.
// ----------------------------------------------------------------------------
module heater_triac_duty_controller (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  hdc_pkg::t_in_word              i_word,
    output logic                           o_stall,
    output logic                           o_valid,
    output hdc_pkg::t_out_word             o_word,
    input  logic                           i_stall,
    input  logic                           i_cfg_valid,
    input  logic [hdc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    output logic                           o_cfg_ready
);

    logic               r_in_valid;
    hdc_pkg::t_in_word  r_in_word;
    logic               r_out_valid;
    hdc_pkg::t_out_word r_out_word;

    logic               adv;
    logic               step;
    hdc_pkg::t_cfg_wr   cfg_wr;
    hdc_pkg::t_out_word result;

    assign adv     = !r_out_valid || !i_stall;
    assign step    = r_in_valid && adv;
    assign o_stall = r_in_valid && !adv;

    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    hdc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_wr),
        .i_step   (step),
        .i_word   (r_in_word),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (adv) begin
                r_out_valid <= step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_word <= i_word;
        end
        if (step) begin
            r_out_word <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;

endmodule

[test/heater_triac_duty_controller_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heater_triac_duty_controller_test: self-checking bench for the heater PWM
// Drives tick and set words with random gaps and output back-pressure, keeps
// a cycle-free model of the period timer, PWM position, delay and relay latch,
// and compares every result word field by field against it. Register settings
// change between phases, including the zero and full-scale extremes.
// ----------------------------------------------------------------------------
module heater_triac_duty_controller_test;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    hdc_pkg::t_in_word   i_word = '0;
    logic       o_stall;
    logic       o_valid;
    hdc_pkg::t_out_word  o_word;
    logic       i_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [hdc_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;
    logic       o_cfg_ready;

    heater_triac_duty_controller u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_word      (i_word),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_word      (o_word),
        .i_stall     (i_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    // controller model state
    logic [7:0] cfg_period = hdc_pkg::RESET_PERIOD_TICKS;
    logic [7:0] cfg_cycle  = hdc_pkg::RESET_CYCLE_TICKS;
    logic [7:0] period_cnt = '0;
    logic [7:0] pwm_pos    = '0;
    logic [7:0] duty_ticks = '0;
    logic       relay_q    = 1'b0;
    logic       triac_q    = 1'b0;
    logic       pend_relay = 1'b0;
    logic [7:0] pend_duty  = '0;
    logic [7:0] delay_cnt  = '0;

    hdc_pkg::t_out_word  expected_results[$];
    hdc_pkg::t_out_word  want_word;
    int         error_count = 0;
    bit         src_idle_on = 1'b1;
    bit         sink_idle_on = 1'b1;
    int         holdoff_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic hdc_pkg::t_out_word heater_step(hdc_pkg::t_in_word w);
        hdc_pkg::t_out_word  r;
        logic [8:0]  nxt;
        logic [15:0] prod;
        if (w.command == hdc_pkg::CMD_SET) begin
            pend_relay = w.relay_request;
            pend_duty  = w.duty_percent;
            delay_cnt  = w.delay_periods;
        end else begin
            if (period_cnt < cfg_period)
                period_cnt = period_cnt + 8'd1;
            triac_q = (duty_ticks != 8'd0) && (pwm_pos <= duty_ticks);
            nxt = {1'b0, pwm_pos} + 9'd1;
            pwm_pos = (nxt > {1'b0, cfg_cycle} || nxt > 9'd255) ? 8'd0 : nxt[7:0];
            if (period_cnt >= cfg_period) begin
                period_cnt = '0;
                if (delay_cnt != 8'd0)
                    delay_cnt = delay_cnt - 8'd1;
                if (delay_cnt == 8'd0) begin
                    relay_q = pend_relay;
                    if (pend_duty >= hdc_pkg::FULL_PERCENT) begin
                        duty_ticks = cfg_cycle;
                    end else begin
                        prod = 16'(pend_duty) * 16'(cfg_cycle);
                        duty_ticks = 8'(prod / 16'(hdc_pkg::FULL_PERCENT));
                    end
                end
            end
        end
        r.relay_on       = relay_q;
        r.triac_on       = triac_q;
        r.heater_status  = {relay_q, triac_q};
        r.requested_duty = pend_duty;
        return r;
    endfunction

    function automatic hdc_pkg::t_in_word random_command();
        hdc_pkg::t_in_word w;
        w.relay_request = 1'($urandom);
        w.duty_percent  = 8'($urandom);
        w.delay_periods = 8'($urandom);
        w.command = ($urandom_range(0, 4) == 0) ? hdc_pkg::CMD_SET : hdc_pkg::CMD_TICK;
        if (w.command == hdc_pkg::CMD_SET) begin
            if ($urandom_range(0, 9) < 7)
                w.delay_periods = 8'($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 0)
                w.duty_percent = 8'($urandom_range(0, 110));
        end
        return w;
    endfunction

    function automatic hdc_pkg::t_in_word make_word(hdc_pkg::t_cmd cmd, logic relay,
                                                    logic [7:0] duty, logic [7:0] delay);
        hdc_pkg::t_in_word w;
        w.command       = cmd;
        w.relay_request = relay;
        w.duty_percent  = duty;
        w.delay_periods = delay;
        return w;
    endfunction

    task automatic send_word(input hdc_pkg::t_in_word w);
        int gap;
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_word  <= w;
        do @(posedge i_clk); while (o_stall);
        expected_results.push_back(heater_step(w));
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_word(make_word(hdc_pkg::CMD_TICK, 1'($urandom), 8'($urandom),
                                       8'($urandom)));
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_results.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        if (expected_results.size() != 0) begin
            $error("%0d result words never arrived", expected_results.size());
            error_count++;
            expected_results.delete();
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input hdc_pkg::t_cfg_idx idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == hdc_pkg::CFG_CONTROL_PERIOD)
            cfg_period = val;
        else
            cfg_cycle = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] period, input logic [7:0] cycle);
        drain_results();
        write_reg(hdc_pkg::CFG_CONTROL_PERIOD, period);
        write_reg(hdc_pkg::CFG_PWM_CYCLE, cycle);
    endtask

    task automatic test_reset_state();
        send_ticks(3);
        send_word(make_word(hdc_pkg::CMD_SET, 1'b1, 8'd255, 8'd255));
        send_ticks(1);
        send_word(make_word(hdc_pkg::CMD_SET, 1'b0, 8'd0, 8'd0));
    endtask

    task automatic test_directed_pwm();
        set_config(8'd2, 8'd4);
        send_word(make_word(hdc_pkg::CMD_SET, 1'b1, 8'd50, 8'd0));
        send_ticks(6);
        send_word(make_word(hdc_pkg::CMD_SET, 1'b0, 8'd100, 8'd2));
        send_ticks(6);
        send_word(make_word(hdc_pkg::CMD_SET, 1'b1, 8'd0, 8'd1));
        send_ticks(4);
    endtask

    task automatic test_register_edges();
        logic [7:0] periods[5] = '{8'd1, 8'd255, 8'd0, 8'd1, 8'd0};
        logic [7:0] cycles[5]  = '{8'd255, 8'd1, 8'd0, 8'd1, 8'd255};
        for (int k = 0; k < 5; k++) begin
            set_config(periods[k], cycles[k]);
            send_word(make_word(hdc_pkg::CMD_SET, 1'($urandom), 8'd100, 8'd0));
            send_ticks(8);
            send_word(make_word(hdc_pkg::CMD_SET, 1'($urandom),
                                8'($urandom_range(1, 99)), 8'd1));
            send_ticks(8);
        end
        // lower the period below the running timer
        set_config(8'd10, 8'd6);
        send_word(make_word(hdc_pkg::CMD_SET, 1'b1, 8'd60, 8'd0));
        send_ticks(6);
        drain_results();
        write_reg(hdc_pkg::CFG_CONTROL_PERIOD, 8'd3);
        send_ticks(4);
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 7; ph++) begin
            if ($urandom_range(0, 4) != 0)
                set_config(8'($urandom_range(1, 8)), 8'($urandom_range(1, 12)));
            else
                set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            repeat (64) send_word(random_command());
        end
    endtask

    task automatic test_backpressure();
        set_config(8'd3, 8'd5);
        holdoff_cycles = 300;
        repeat (40) send_word(random_command());
    endtask

    task automatic test_steady_stream();
        set_config(8'd2, 8'd7);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        repeat (80) send_word(random_command());
    endtask

    initial begin : receiver
        int n;
        forever begin
            @(negedge i_clk);
            if (holdoff_cycles > 0) begin
                n = holdoff_cycles;
                holdoff_cycles = 0;
                i_stall <= 1'b1;
            end else if (sink_idle_on && $urandom_range(0, 2) == 0) begin
                n = $urandom_range(1, 18);
                i_stall <= 1'b1;
            end else begin
                n = sink_idle_on ? $urandom_range(1, 18) : 1;
                i_stall <= 1'b0;
            end
            repeat (n - 1) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result word %h", o_word);
                error_count++;
            end else begin
                want_word = expected_results.pop_front();
                if (o_word.relay_on !== want_word.relay_on) begin
                    $error("relay_on: expected %0d, actual %0d",
                           want_word.relay_on, o_word.relay_on);
                    error_count++;
                end
                if (o_word.triac_on !== want_word.triac_on) begin
                    $error("triac_on: expected %0d, actual %0d",
                           want_word.triac_on, o_word.triac_on);
                    error_count++;
                end
                if (o_word.heater_status !== want_word.heater_status) begin
                    $error("heater_status: expected %0d, actual %0d",
                           want_word.heater_status, o_word.heater_status);
                    error_count++;
                end
                if (o_word.requested_duty !== want_word.requested_duty) begin
                    $error("requested_duty: expected %0d, actual %0d",
                           want_word.requested_duty, o_word.requested_duty);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #3000000;
        $display("** heater_triac_duty_controller: FAILED **");
        $finish;
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_directed_pwm();
        test_register_edges();
        test_random_phases();
        test_backpressure();
        test_steady_stream();
        drain_results();
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("** heater_triac_duty_controller: PASSED **");
        end else begin
            $display("** heater_triac_duty_controller: FAILED **");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/hdc_pkg.sv
hw/rtl/hdc_core.sv
hw/rtl/heater_triac_duty_controller.sv
test/heater_triac_duty_controller_test.sv
